// File: src/arpnc_pkg.sv
// ----------------------------------------------------------------------------
// arpnc_pkg
// Shared constants and types for the ARP neighbor cache.
// ----------------------------------------------------------------------------
package arpnc_pkg;

  localparam int SLOT_COUNT = 32;
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  localparam logic [31:0] ALL_IP  = 32'hFFFF_FFFF;
  localparam logic [47:0] MAC_ALL = 48'hFFFF_FFFF_FFFF;

  localparam logic REQ_STORE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_RESP
  } arpnc_state_t;

endpackage

// File: src/arp_neighbor_cache.sv
// ----------------------------------------------------------------------------
// arp_neighbor_cache
// IPv4-to-MAC neighbor cache with a fixed number of slots.
// ----------------------------------------------------------------------------
// A store word writes an IP/MAC/time mapping into the slot that already holds
// the IP, else the first free slot, else the first slot with the oldest time.
// A lookup word returns the broadcast MAC for broadcast addresses, otherwise
// the MAC of the first valid matching slot. Every non-ignored store or
// non-broadcast lookup scans all SLOT_COUNT slots through one read port of
// the slot memory, one slot per cycle with one address compare and one time
// compare. Broadcast lookups and ignored stores (address zero or all ones)
// skip the scan. The block accepts one word at a time; a finished result
// waits in the output register while the next word is taken. Valid bits
// clear at reset; no clearing pass is needed. cfg_ready is always high.
// ----------------------------------------------------------------------------
module arp_neighbor_cache import arpnc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        req_type,
  input  logic [31:0] entry_ip,
  input  logic [47:0] entry_mac,
  input  logic [47:0] now_ms,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic        found,
  output logic        is_broadcast,
  output logic [47:0] result_mac
);

  arpnc_state_t state, state_next;

  logic [31:0] subnet_mask;

  // Slot storage.
  logic [SLOT_COUNT-1:0] slot_valid;
  logic [31:0] ip_mem    [SLOT_COUNT];
  logic [47:0] mac_mem   [SLOT_COUNT];
  logic [47:0] stamp_mem [SLOT_COUNT];

  // Latched request.
  logic        op_store;
  logic        op_bcast;
  logic [31:0] op_ip;
  logic [47:0] op_mac;
  logic [47:0] op_stamp;

  // Scan pipeline.
  logic [CNT_W-1:0] scan_cnt;
  logic [IDX_W-1:0] rd_addr;
  logic             issue;
  logic             q_vld;
  logic [IDX_W-1:0] q_idx;
  logic [31:0]      rd_ip;
  logic [47:0]      rd_mac;
  logic [47:0]      rd_stamp;
  logic             scan_last;

  // Scan results.
  logic             hit_flag;
  logic [IDX_W-1:0] hit_idx;
  logic [47:0]      hit_mac;
  logic             free_flag;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] old_idx;
  logic [47:0]      old_stamp;
  logic [IDX_W-1:0] wr_idx;

  logic accept;
  logic rsp_free;
  logic load_rsp;
  logic is_bcast_ip;
  logic ignore_store;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  assign is_bcast_ip  = (entry_ip == ALL_IP) ||
                        ((subnet_mask != '0) && ((entry_ip | subnet_mask) == ALL_IP));
  assign ignore_store = (entry_ip == '0) || (entry_ip == ALL_IP);

  assign issue     = (state == ST_SCAN) && (scan_cnt < CNT_W'(SLOT_COUNT));
  assign rd_addr   = scan_cnt[IDX_W-1:0];
  assign scan_last = q_vld && (q_idx == IDX_W'(SLOT_COUNT - 1));
  assign wr_idx    = hit_flag ? hit_idx : (free_flag ? free_idx : old_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load_rsp   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req_type == REQ_LOOKUP) begin
            state_next = is_bcast_ip ? ST_RESP : ST_SCAN;
          end else if (!ignore_store) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = op_store ? ST_WRITE : ST_RESP;
        end
      end
      ST_WRITE: begin
        state_next = ST_IDLE;
      end
      ST_RESP: begin
        if (rsp_free) begin
          load_rsp   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      subnet_mask <= '0;
    end else if (cfg_valid && cfg_ready) begin
      subnet_mask <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_store <= (req_type == REQ_STORE);
      op_bcast <= is_bcast_ip;
      op_ip    <= entry_ip;
      op_mac   <= entry_mac;
      op_stamp <= now_ms;
    end
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (state == ST_WRITE) begin
      ip_mem[wr_idx]    <= op_ip;
      mac_mem[wr_idx]   <= op_mac;
      stamp_mem[wr_idx] <= op_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_ip    <= ip_mem[rd_addr];
      rd_mac   <= mac_mem[rd_addr];
      rd_stamp <= stamp_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (state == ST_WRITE) begin
      slot_valid[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
      q_vld    <= 1'b0;
    end else begin
      if (accept) begin
        scan_cnt <= '0;
      end else if (issue) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
      q_vld <= issue;
    end
  end

  always_ff @(posedge clk) begin
    q_idx <= rd_addr;
  end

  // One slot is judged per cycle. The oldest search covers every slot; its
  // answer is used only when all slots are valid, so every stamp is written.
  always_ff @(posedge clk) begin
    if (accept) begin
      hit_flag  <= 1'b0;
      free_flag <= 1'b0;
    end else if (q_vld) begin
      if (slot_valid[q_idx] && (rd_ip == op_ip) && !hit_flag) begin
        hit_flag <= 1'b1;
        hit_idx  <= q_idx;
        hit_mac  <= rd_mac;
      end
      if (!slot_valid[q_idx] && !free_flag) begin
        free_flag <= 1'b1;
        free_idx  <= q_idx;
      end
      if ((q_idx == '0) || (rd_stamp < old_stamp)) begin
        old_idx   <= q_idx;
        old_stamp <= rd_stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      if (op_bcast) begin
        found        <= 1'b1;
        is_broadcast <= 1'b1;
        result_mac   <= MAC_ALL;
      end else begin
        found        <= hit_flag;
        is_broadcast <= 1'b0;
        result_mac   <= hit_flag ? hit_mac : '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_bcast_word: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && is_broadcast |-> found && (result_mac == MAC_ALL))
    else $error("broadcast result without found flag or broadcast MAC");

  a_miss_word: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !found |-> (result_mac == '0) && !is_broadcast)
    else $error("miss result carries a nonzero MAC");

  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    q_vld |-> (state == ST_SCAN))
    else $error("slot read data outside of a scan");

  a_write_once: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |=> (state == ST_IDLE) && slot_valid[$past(wr_idx)])
    else $error("slot write did not complete in one cycle");
`endif

endmodule

// File: tb/arp_neighbor_cache_tb.sv
// ----------------------------------------------------------------------------
// arp_neighbor_cache_tb
// Self-checking testbench for the ARP neighbor cache. A directed table covers
// the broadcast, ignored-store, overwrite and field-extreme cases. Random
// phases under several subnet masks then exercise hits, misses, slot refill
// and oldest-entry eviction against a cycle-free model of the cache.
// ----------------------------------------------------------------------------
module arp_neighbor_cache_tb import arpnc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  POOL_SIZE    = 48;
  localparam int  PHASE_ITEMS  = 170;
  localparam int  PHASE_COUNT  = 5;
  localparam int  HOLD_CYCLES  = 400;
  localparam int  DRAIN_CYCLES = SLOT_COUNT + 8;
  localparam int  CYCLE_LIMIT  = 500000;
  localparam int  DIR_ROWS     = 18;

  typedef struct packed {
    logic        found;
    logic        bcast;
    logic [47:0] mac;
  } lookup_rsp_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [47:0] now;
    logic        typed;
    lookup_rsp_t rsp;
  } req_row_t;

  localparam lookup_rsp_t RSP_MISS  = '{1'b0, 1'b0, 48'h0};
  localparam lookup_rsp_t RSP_BCAST = '{1'b1, 1'b1, MAC_ALL};
  localparam lookup_rsp_t RSP_NONE  = '{1'b0, 1'b0, 48'h0};

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  logic        req_valid;
  logic        req_stall;
  logic        req_type;
  logic [31:0] entry_ip;
  logic [47:0] entry_mac;
  logic [47:0] now_ms;
  logic        rsp_valid;
  logic        rsp_stall;
  logic        found;
  logic        is_broadcast;
  logic [47:0] result_mac;

  // Model of the cache contents and the interface mask.
  logic        cache_valid [SLOT_COUNT];
  logic [31:0] cache_ip    [SLOT_COUNT];
  logic [47:0] cache_mac   [SLOT_COUNT];
  logic [47:0] cache_stamp [SLOT_COUNT];
  logic [31:0] iface_mask;

  lookup_rsp_t pending_lookups[$];
  int          mismatch_count;
  int          cycle_count;
  bit          no_idle;
  bit          hold_go;
  bit          hold_done;

  logic [31:0] ip_pool [POOL_SIZE];
  logic [47:0] clock_ms;

  // Mask FFFFFF00 is active while this table runs.
  req_row_t directed_rows [DIR_ROWS] = '{
    '{REQ_LOOKUP, 32'h0A00_0001, 48'h0,            48'h0,            1'b1, RSP_MISS},
    '{REQ_LOOKUP, ALL_IP,        48'h0,            48'h0,            1'b1, RSP_BCAST},
    '{REQ_LOOKUP, 32'h0A00_00FF, 48'h0,            48'h0,            1'b1, RSP_BCAST},
    '{REQ_STORE,  32'h0000_0000, 48'h1234_5678_9ABC, 48'h10,         1'b0, RSP_NONE},
    '{REQ_LOOKUP, 32'h0000_0000, 48'h0,            48'h0,            1'b1, RSP_MISS},
    '{REQ_STORE,  ALL_IP,        48'h1111_2222_3333, 48'h20,         1'b0, RSP_NONE},
    '{REQ_STORE,  32'h0A00_0001, 48'h0,            48'h0,            1'b0, RSP_NONE},
    '{REQ_LOOKUP, 32'h0A00_0001, 48'h0,            48'h0,            1'b0, RSP_NONE},
    '{REQ_STORE,  32'hFFFF_FFFE, MAC_ALL,          48'hFFFF_FFFF_FFFF, 1'b0, RSP_NONE},
    '{REQ_LOOKUP, 32'hFFFF_FFFE, 48'h0,            48'h0,            1'b0, RSP_NONE},
    '{REQ_STORE,  32'h0A00_0001, 48'hAAAA_AAAA_AAAA, 48'h5,          1'b0, RSP_NONE},
    '{REQ_LOOKUP, 32'h0A00_0001, 48'h0,            48'h0,            1'b0, RSP_NONE},
    '{REQ_STORE,  32'h0000_0001, 48'h5555_5555_5555, 48'h8000_0000_0000, 1'b0, RSP_NONE},
    '{REQ_LOOKUP, 32'h0000_0001, 48'h0,            48'h0,            1'b0, RSP_NONE},
    '{REQ_STORE,  32'h0A00_00FF, 48'h0102_0304_0506, 48'h30,         1'b0, RSP_NONE},
    '{REQ_LOOKUP, 32'h0A00_00FF, 48'h0,            48'h0,            1'b1, RSP_BCAST},
    '{REQ_LOOKUP, 32'h0A00_0002, 48'h0,            48'h0,            1'b1, RSP_MISS},
    '{REQ_LOOKUP, 32'h0000_0001, MAC_ALL,          MAC_ALL,          1'b0, RSP_NONE}
  };

  arp_neighbor_cache u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .entry_ip     (entry_ip),
    .entry_mac    (entry_mac),
    .now_ms       (now_ms),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .found        (found),
    .is_broadcast (is_broadcast),
    .result_mac   (result_mac)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles, %0d lookups outstanding",
                 cycle_count, pending_lookups.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Applies one accepted request to the cache model. Returns 1 when the
  // request produces a lookup answer.
  function automatic bit resolve_request(input logic kind, input logic [31:0] ip,
                                         input logic [47:0] mac, input logic [47:0] now,
                                         output lookup_rsp_t rsp);
    int hit;
    int open_slot;
    int oldest;
    hit       = -1;
    open_slot = -1;
    oldest    = 0;
    rsp       = RSP_MISS;
    if (kind == REQ_STORE) begin
      if (ip == 32'd0 || ip == ALL_IP) return 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (cache_valid[i] && cache_ip[i] == ip) begin
          hit = i;
          break;
        end
        if (!cache_valid[i] && open_slot < 0) open_slot = i;
        if (cache_stamp[i] < cache_stamp[oldest]) oldest = i;
      end
      if (hit < 0) hit = (open_slot >= 0) ? open_slot : oldest;
      cache_ip[hit]    = ip;
      cache_mac[hit]   = mac;
      cache_stamp[hit] = now;
      cache_valid[hit] = 1'b1;
      return 1'b0;
    end
    if (ip == ALL_IP || (iface_mask != 32'd0 && (ip | iface_mask) == ALL_IP)) begin
      rsp = RSP_BCAST;
      return 1'b1;
    end
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (cache_valid[i] && cache_ip[i] == ip) begin
        rsp.found = 1'b1;
        rsp.mac   = cache_mac[i];
        break;
      end
    end
    return 1'b1;
  endfunction

  task automatic write_mask(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    iface_mask = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input req_row_t row);
    lookup_rsp_t rsp;
    bit          has_rsp;
    if (!no_idle && $urandom_range(0, 99) < 17) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_type  <= row.kind;
    entry_ip  <= row.ip;
    entry_mac <= row.mac;
    now_ms    <= row.now;
    do @(posedge clk); while (req_stall);
    has_rsp = resolve_request(row.kind, row.ip, row.mac, row.now, rsp);
    if (has_rsp) pending_lookups.push_back(row.typed ? row.rsp : rsp);
    @(negedge clk);
  endtask

  task automatic drain_block();
    req_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    // Stores give no answer, so the last one may still be scanning.
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic req_row_t random_request();
    req_row_t    row;
    int unsigned pick;
    row      = '0;
    row.mac  = 48'({$urandom(), $urandom()});
    pick     = $urandom_range(0, 99);
    clock_ms = clock_ms + 48'($urandom_range(0, 20));
    row.now  = clock_ms;
    if (pick < 45) begin
      row.kind = REQ_STORE;
      row.ip   = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
      if ($urandom_range(0, 9) == 0) row.now = 48'({$urandom(), $urandom()});
    end else if (pick < 80) begin
      row.kind = REQ_LOOKUP;
      row.ip   = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
    end else if (pick < 88) begin
      row.kind = REQ_LOOKUP;
      row.ip   = $urandom();
    end else if (pick < 92) begin
      // Host part all ones: directed broadcast whenever the mask is nonzero.
      row.kind = REQ_LOOKUP;
      row.ip   = $urandom() | ~iface_mask;
    end else if (pick < 96) begin
      row.kind = REQ_STORE;
      row.ip   = $urandom_range(0, 1) ? ALL_IP : 32'd0;
    end else begin
      row.kind = REQ_STORE;
      row.ip   = $urandom();
      row.now  = 48'({$urandom(), $urandom()});
    end
    return row;
  endfunction

  // Answer side: random stalls, one long hold-off and a quiet stretch.
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        rsp_stall <= 1'b1;
        for (int k = 0; k < HOLD_CYCLES; k++) @(negedge clk);
        hold_done = 1'b1;
        rsp_stall <= 1'b0;
      end else if (no_idle) begin
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < 17);
      end
    end
  end

  always @(posedge clk) begin
    lookup_rsp_t exp_rsp;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_lookups.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected answer found=%b bcast=%b mac=%h",
                   $realtime, found, is_broadcast, result_mac);
      end else begin
        exp_rsp = pending_lookups.pop_front();
        if (found !== exp_rsp.found || is_broadcast !== exp_rsp.bcast ||
            result_mac !== exp_rsp.mac) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: answer mismatch exp found=%b bcast=%b mac=%h, got %b %b %h",
                     $realtime, exp_rsp.found, exp_rsp.bcast, exp_rsp.mac,
                     found, is_broadcast, result_mac);
        end
      end
    end
  end

  initial begin
    logic [31:0] phase_masks [PHASE_COUNT];
    rst            = 1'b1;
    cfg_valid      = 1'b0;
    cfg_data       = 32'd0;
    req_valid      = 1'b0;
    req_type       = REQ_STORE;
    entry_ip       = 32'd0;
    entry_mac      = 48'd0;
    now_ms         = 48'd0;
    mismatch_count = 0;
    no_idle        = 1'b0;
    hold_go        = 1'b0;
    hold_done      = 1'b0;
    iface_mask     = 32'd0;
    clock_ms       = {16'd0, $urandom()};
    for (int i = 0; i < SLOT_COUNT; i++) begin
      cache_valid[i] = 1'b0;
      cache_ip[i]    = 32'd0;
      cache_mac[i]   = 48'd0;
      cache_stamp[i] = 48'd0;
    end
    phase_masks = '{32'h0000_0000, 32'hFFFF_F000, 32'hFFFF_FFFF, $urandom(),
                    32'hFFFF_FF00};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_mask(32'hFFFF_FF00);
    for (int r = 0; r < DIR_ROWS; r++) send_request(directed_rows[r]);
    drain_block();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_mask(phase_masks[p]);
      // A fresh address set per phase; 48 addresses keep the 32 slots churning.
      for (int i = 0; i < POOL_SIZE; i++) begin
        do ip_pool[i] = $urandom(); while (ip_pool[i] == 32'd0 || ip_pool[i] == ALL_IP);
      end
      if (p == 1) hold_go = 1'b1;
      no_idle = (p == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) send_request(random_request());
      no_idle = 1'b0;
      drain_block();
    end

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
